// File: hdl/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

    localparam int MAX_FIELDS_DEF  = 8;
    localparam int FIELD_BYTES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int NUM_SLOTS       = 3;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;

    localparam logic [1:0] BOM_NONE = 2'd0;
    localparam logic [1:0] BOM_ONE  = 2'd1;
    localparam logic [1:0] BOM_TWO  = 2'd2;
    localparam logic [1:0] BOM_FULL = 2'd3;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_LINE  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] field_number;
        logic [7:0] position;
        logic [7:0] char_value;
        logic [7:0] trimmed_length;
        logic [3:0] fields_found;
    } result_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]    valid;
        result_t [NUM_SLOTS-1:0] rec;
    } entry_t;

    function automatic logic is_blank(logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF) ||
               (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

// File: hdl/cft_queue.sv
`timescale 1ns / 1ps

module cft_queue
    import cft_pkg::*;
#(
    parameter int WIDTH = $bits(entry_t),
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("queue occupancy beyond its depth");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("push into a full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

// File: hdl/cft_front.sv
`timescale 1ns / 1ps

module cft_front
    import cft_pkg::*;
#(
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       line_end,
    output logic       push,
    output entry_t     push_entry,
    input  logic       queue_full
);

    localparam int LW = $clog2(FIELD_BYTES);
    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam int EW = (LW > 8) ? LW : 8;
    localparam int EC = (CW > 4) ? CW : 4;

    typedef struct packed {
        logic [LW-1:0] start;
        logic [LW-1:0] len;
    } span_t;

    logic          inq_reg, inq_next;
    logic          qp_reg, qp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    bom_reg, bom_next;
    logic [LW-1:0] fk_reg, fk_next;
    logic [LW-1:0] fkab_reg, fkab_next;
    logic [LW-1:0] kend_reg, kend_next;
    logic [1:0]    flags_reg, flags_next;

    entry_t ent;
    span_t  sp;
    logic   do_store;
    logic   do_close;
    logic   skip;
    logic   finish;
    logic   accept;

    function automatic span_t close_span(logic [1:0] bom, logic [1:0] flags,
                                         logic [LW-1:0] fk, logic [LW-1:0] fkab,
                                         logic [LW-1:0] kend);
        span_t s;
        s = '0;
        if (bom == BOM_FULL)
        begin
            if (flags[1])
            begin
                s.start = fkab;
                s.len   = kend - fkab;
            end
        end
        else if (flags[0])
        begin
            s.start = fk;
            s.len   = kend - fk;
        end
        return s;
    endfunction

    function automatic logic [7:0] to8(logic [LW-1:0] v);
        logic [EW-1:0] w;
        w = EW'(v);
        return w[7:0];
    endfunction

    function automatic logic [3:0] cnt4(logic [CW-1:0] v);
        logic [EC-1:0] w;
        w = EC'(v);
        return w[3:0];
    endfunction

    function automatic logic [2:0] fnum3(logic [CW-1:0] v);
        logic [EC-1:0] w;
        w = EC'(v);
        return w[2:0];
    endfunction

    always_comb
    begin
        inq_next   = inq_reg;
        qp_next    = qp_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        bom_next   = bom_reg;
        fk_next    = fk_reg;
        fkab_next  = fkab_reg;
        kend_next  = kend_reg;
        flags_next = flags_reg;
        ent        = '0;
        sp         = '0;
        do_store   = 1'b0;
        do_close   = 1'b0;
        skip       = 1'b0;
        finish     = (data_byte == CH_NUL) || line_end;

        if (data_byte != CH_NUL && cnt_reg < CW'(MAX_FIELDS))
        begin
            if (qp_reg)
            begin
                qp_next = 1'b0;
                if (data_byte == CH_QUOTE)
                begin
                    do_store = 1'b1;
                    skip     = 1'b1;
                end
                else
                begin
                    inq_next = 1'b0;
                end
            end
            if (!skip)
            begin
                if (data_byte == CH_QUOTE)
                begin
                    if (inq_next)
                    begin
                        qp_next = 1'b1;
                    end
                    else
                    begin
                        inq_next = 1'b1;
                    end
                end
                else if (data_byte == CH_COMMA && !inq_next)
                begin
                    do_close = 1'b1;
                end
                else if (data_byte != CH_LF && data_byte != CH_CR)
                begin
                    do_store = 1'b1;
                end
            end
        end

        if (do_store && len_reg < LW'(FIELD_BYTES - 1))
        begin
            if (len_reg == LW'(0))
            begin
                bom_next = (data_byte == BOM_0) ? BOM_ONE : BOM_NONE;
            end
            else if (len_reg == LW'(1))
            begin
                bom_next = (bom_reg == BOM_ONE && data_byte == BOM_1) ? BOM_TWO : BOM_NONE;
            end
            else if (len_reg == LW'(2))
            begin
                bom_next = (bom_reg == BOM_TWO && data_byte == BOM_2) ? BOM_FULL : BOM_NONE;
            end
            if (!is_blank(data_byte))
            begin
                if (!flags_reg[0])
                begin
                    fk_next       = len_reg;
                    flags_next[0] = 1'b1;
                end
                if (len_reg >= LW'(3) && !flags_reg[1])
                begin
                    fkab_next     = len_reg;
                    flags_next[1] = 1'b1;
                end
                kend_next = len_reg + LW'(1);
            end
            ent.valid[0]               = 1'b1;
            ent.rec[0].kind            = KIND_BYTE;
            ent.rec[0].field_number    = fnum3(cnt_reg);
            ent.rec[0].position        = to8(len_reg);
            ent.rec[0].char_value      = data_byte;
            len_next                   = len_reg + LW'(1);
        end

        if (do_close)
        begin
            sp = close_span(bom_reg, flags_reg, fk_reg, fkab_reg, kend_reg);
            ent.valid[0]               = 1'b1;
            ent.rec[0].kind            = KIND_CLOSE;
            ent.rec[0].field_number    = fnum3(cnt_reg);
            ent.rec[0].position        = to8(sp.start);
            ent.rec[0].trimmed_length  = to8(sp.len);
            cnt_next   = cnt_reg + CW'(1);
            len_next   = '0;
            bom_next   = BOM_NONE;
            fk_next    = '0;
            fkab_next  = '0;
            kend_next  = '0;
            flags_next = '0;
        end

        if (finish)
        begin
            qp_next  = 1'b0;
            inq_next = 1'b0;
            if (cnt_next < CW'(MAX_FIELDS))
            begin
                sp = close_span(bom_next, flags_next, fk_next, fkab_next, kend_next);
                ent.valid[1]               = 1'b1;
                ent.rec[1].kind            = KIND_CLOSE;
                ent.rec[1].field_number    = fnum3(cnt_next);
                ent.rec[1].position        = to8(sp.start);
                ent.rec[1].trimmed_length  = to8(sp.len);
                cnt_next = cnt_next + CW'(1);
            end
            ent.valid[2]             = 1'b1;
            ent.rec[2].kind          = KIND_LINE;
            ent.rec[2].fields_found  = cnt4(cnt_next);
            cnt_next   = '0;
            len_next   = '0;
            bom_next   = BOM_NONE;
            fk_next    = '0;
            fkab_next  = '0;
            kend_next  = '0;
            flags_next = '0;
        end
    end

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    assign push       = accept && (ent.valid != '0);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg   <= 1'b0;
            qp_reg    <= 1'b0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            bom_reg   <= BOM_NONE;
            fk_reg    <= '0;
            fkab_reg  <= '0;
            kend_reg  <= '0;
            flags_reg <= '0;
        end
        else if (accept)
        begin
            inq_reg   <= inq_next;
            qp_reg    <= qp_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            bom_reg   <= bom_next;
            fk_reg    <= fk_next;
            fkab_reg  <= fkab_next;
            kend_reg  <= kend_next;
            flags_reg <= flags_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(MAX_FIELDS))
        else $error("field counter passed the field limit");
    assert property (@(posedge clk) disable iff (!rst_n) qp_reg |-> inq_reg)
        else $error("pending quote outside a quoted section");

endmodule

// File: hdl/cft_back.sv
`timescale 1ns / 1ps

module cft_back
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  entry_t     head_entry,
    input  logic       queue_empty,
    output logic       pop,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] kind,
    output logic [2:0] field_number,
    output logic [7:0] position,
    output logic [7:0] char_value,
    output logic [7:0] trimmed_length,
    output logic [3:0] fields_found,
    output logic       last_result
);

    logic [NUM_SLOTS-1:0]    mask_reg, mask_next;
    result_t [NUM_SLOTS-1:0] rec_reg;
    logic [1:0]              idx;
    logic [NUM_SLOTS-1:0]    rest;
    result_t                 cur;
    logic                    take;
    logic                    done;

    always_comb
    begin
        if (mask_reg[0])
        begin
            idx = 2'd0;
        end
        else if (mask_reg[1])
        begin
            idx = 2'd1;
        end
        else
        begin
            idx = 2'd2;
        end
    end

    always_comb
    begin
        rest      = mask_reg;
        rest[idx] = 1'b0;
    end

    assign cur            = rec_reg[idx];
    assign result_valid   = (mask_reg != '0);
    assign kind           = cur.kind;
    assign field_number   = cur.field_number;
    assign position       = cur.position;
    assign char_value     = cur.char_value;
    assign trimmed_length = cur.trimmed_length;
    assign fields_found   = cur.fields_found;
    assign last_result    = (rest == '0);

    assign take = result_valid && result_ready;
    assign done = !result_valid || (take && rest == '0);
    assign pop  = done && !queue_empty;

    always_comb
    begin
        mask_next = mask_reg;
        if (pop)
        begin
            mask_next = head_entry.valid;
        end
        else if (take)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= head_entry.rec;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid && kind == KIND_LINE) |-> last_result)
        else $error("line result is not the last of its beat group");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid && kind == KIND_BYTE) |->
                     (trimmed_length == 8'd0 && fields_found == 4'd0))
        else $error("stored byte result carries close or line data");

endmodule

// File: hdl/csv_field_tokenizer.sv
`timescale 1ns / 1ps
// The first result beat of a byte is written into the queue when the byte is accepted and
// is valid once the result sequencer has loaded it from the queue head into its registers.
// Throughput: one input byte per cycle while the queue is not full and one result beat per
// cycle while result_ready is high; a byte that causes several results holds the result port
// until all are taken, and the queue between classifier and result sequencer absorbs the difference.
// Reset (rst_n, asynchronous, active low) clears the quote, field and line state and the queue.

module csv_field_tokenizer
    import cft_pkg::*;
#(
    parameter int MAX_FIELDS  = MAX_FIELDS_DEF,
    parameter int FIELD_BYTES = FIELD_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [7:0] data_byte,
    input  logic       line_end,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] kind,
    output logic [2:0] field_number,
    output logic [7:0] position,
    output logic [7:0] char_value,
    output logic [7:0] trimmed_length,
    output logic [3:0] fields_found,
    output logic       last_result
);

    entry_t push_entry;
    entry_t head_entry;
    logic   push;
    logic   pop;
    logic   queue_full;
    logic   queue_empty;

    cft_front #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FIELD_BYTES (FIELD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .data_byte  (data_byte),
        .line_end   (line_end),
        .push       (push),
        .push_entry (push_entry),
        .queue_full (queue_full)
    );

    cft_queue #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head_entry),
        .empty     (queue_empty)
    );

    cft_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_entry     (head_entry),
        .queue_empty    (queue_empty),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .field_number   (field_number),
        .position       (position),
        .char_value     (char_value),
        .trimmed_length (trimmed_length),
        .fields_found   (fields_found),
        .last_result    (last_result)
    );

endmodule
